// ===== rtl/core/addressable_led_frame_driver_unit_macros.svh =====
// Assertion helpers shared by the RTL of the LED frame driver.
// Both sample on posedge clk and are disabled while rst_n is low.
`ifndef ADDRESSABLE_LED_FRAME_DRIVER_UNIT_MACROS_SVH
`define ADDRESSABLE_LED_FRAME_DRIVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define ALED_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aled check failed");

// Consequent must hold in the cycle after the antecedent.
`define ALED_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aled check failed");

`else

`define ALED_ASSERT_NOW(label, ante, cons)
`define ALED_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/aled_pkg.sv =====
`default_nettype none

package aled_pkg;

  // Command codes on in_op
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_FILL = 2'd2,
    OP_SHOW = 2'd3
  } op_t;

  // Bit timing, in ticks
  localparam logic [3:0]  LAST_SLOT   = 4'd9;
  localparam logic [3:0]  HIGH_ONE    = 4'd7;
  localparam logic [3:0]  HIGH_ZERO   = 4'd2;
  localparam logic [4:0]  LAST_BIT    = 5'd23;
  localparam int          PIXEL_BITS  = 24;
  localparam logic [15:0] LATCH_RESET = 16'd2400;

  // Stored pixels are R,G,B; the wire order is G,R,B
  function automatic logic [PIXEL_BITS-1:0] grb_of(input logic [PIXEL_BITS-1:0] rgb);
    return {rgb[15:8], rgb[23:16], rgb[7:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aled_ram.sv =====
`default_nettype none

module aled_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/addressable_led_frame_driver_unit.sv =====
`default_nettype none
`include "addressable_led_frame_driver_unit_macros.svh"

// Serial driver for a chain of addressable RGB LEDs. A command (tick, set
// pixel, fill, show) is taken at a clock edge where start is high and busy is
// low; its result is on out_* for exactly one cycle, flagged by out_valid, in
// the cycle right after the transfer. The receiver cannot stall: it must take
// each result the cycle it appears. Most commands leave busy low, so a new
// one can follow every cycle. A show, and a tick that moves on to the next
// pixel, hold busy high (state C_LOAD) while the next pixel comes out of the
// pixel store's registered read port. Each tick moves the line waveform by
// one slot; the bit being sent shifts out of a 24-bit register one bit per 10
// ticks. Fill, while no frame is being sent, sets a fill color and drops all
// per-pixel valid bits; a pixel without a valid bit reads as the fill color.
module addressable_led_frame_driver_unit #(
  parameter int NUM_PIXELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_index,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  // result channel
  output logic        out_valid,
  output logic        out_line,
  output logic        out_busy_res,
  output logic        out_accepted,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  import aled_pkg::*;

  localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

  typedef enum logic {
    C_IDLE,
    C_LOAD
  } ctl_state_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SEND  = 2'd1,
    S_LATCH = 2'd2
  } send_state_t;

  ctl_state_t              ctl_r, ctl_nxt;
  send_state_t             send_r, send_nxt;
  logic [AW-1:0]           pix_r, pix_nxt;
  logic [4:0]              bit_r, bit_nxt;
  logic [3:0]              slot_r, slot_nxt;
  logic [PIXEL_BITS-1:0]   shift_r, shift_nxt;
  logic [15:0]             latch_cnt_r, latch_cnt_nxt;
  logic [15:0]             latch_ticks_r, latch_ticks_nxt;
  logic [PIXEL_BITS-1:0]   fill_r, fill_nxt;
  logic [NUM_PIXELS-1:0]   valid_r, valid_nxt;
  logic                    vld_q_r, vld_q_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_line_r, out_line_nxt;
  logic                    out_busy_r, out_busy_nxt;
  logic                    out_acc_r, out_acc_nxt;

  logic                    accept;
  logic                    level;
  logic [PIXEL_BITS-1:0]   rgb;
  logic                    ram_we;
  logic                    ram_re;
  logic [AW-1:0]           ram_rd_addr;
  logic [PIXEL_BITS-1:0]   ram_rdata;

  assign busy   = (ctl_r != C_IDLE);
  assign accept = start && !busy;
  assign rgb    = {in_red, in_green, in_blue};

  // line level of the slot now being sent
  assign level = (send_r == S_SEND) &&
                 (slot_r < (shift_r[PIXEL_BITS-1] ? HIGH_ONE : HIGH_ZERO));

  aled_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (NUM_PIXELS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (in_index[AW-1:0]),
    .wr_data (rgb),
    .rd_en   (ram_re),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rdata)
  );

  // Next-state logic
  always_comb begin
    logic              idle;
    logic              in_range;
    logic [15:0]       cnt_dec;
    idle          = (send_r == S_IDLE);
    in_range      = ({1'b0, in_index} < 9'(NUM_PIXELS));
    cnt_dec       = (latch_cnt_r != '0) ? latch_cnt_r - 16'd1 : latch_cnt_r;

    ctl_nxt         = ctl_r;
    send_nxt        = send_r;
    pix_nxt         = pix_r;
    bit_nxt         = bit_r;
    slot_nxt        = slot_r;
    shift_nxt       = shift_r;
    latch_cnt_nxt   = latch_cnt_r;
    latch_ticks_nxt = cfg_wr_en ? cfg_wr_data : latch_ticks_r;
    fill_nxt        = fill_r;
    valid_nxt       = valid_r;
    vld_q_nxt       = vld_q_r;
    out_valid_nxt   = 1'b0;
    out_line_nxt    = out_line_r;
    out_busy_nxt    = out_busy_r;
    out_acc_nxt     = out_acc_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_rd_addr     = '0;

    if (ctl_r == C_LOAD) begin
      // pixel word arrives from the store
      shift_nxt = grb_of(vld_q_r ? ram_rdata : fill_r);
      ctl_nxt   = C_IDLE;
    end else if (accept) begin
      out_valid_nxt = 1'b1;
      out_acc_nxt   = 1'b0;
      out_line_nxt  = level;
      case (op_t'(in_op))
        OP_TICK: begin
          case (send_r)
            S_LATCH: begin
              latch_cnt_nxt = cnt_dec;
              if (cnt_dec == '0) begin
                send_nxt = S_IDLE;
              end
            end
            S_SEND: begin
              if (slot_r != LAST_SLOT) begin
                slot_nxt = slot_r + 4'd1;
              end else begin
                slot_nxt  = '0;
                shift_nxt = {shift_r[PIXEL_BITS-2:0], 1'b0};
                if (bit_r != LAST_BIT) begin
                  bit_nxt = bit_r + 5'd1;
                end else begin
                  bit_nxt = '0;
                  if (pix_r != AW'(NUM_PIXELS - 1)) begin
                    // fetch the next pixel
                    pix_nxt     = pix_r + AW'(1);
                    ram_re      = 1'b1;
                    ram_rd_addr = pix_r + AW'(1);
                    vld_q_nxt   = valid_r[pix_r + AW'(1)];
                    ctl_nxt     = C_LOAD;
                  end else begin
                    // frame done, start latch time
                    pix_nxt       = '0;
                    shift_nxt     = '0;
                    latch_cnt_nxt = latch_ticks_r;
                    send_nxt      = (latch_ticks_r == '0) ? S_IDLE : S_LATCH;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
        OP_SET: begin
          if (idle && in_range) begin
            ram_we                       = 1'b1;
            valid_nxt[in_index[AW-1:0]]  = 1'b1;
            out_acc_nxt                  = 1'b1;
          end
        end
        OP_FILL: begin
          if (idle) begin
            fill_nxt    = rgb;
            valid_nxt   = '0;
            out_acc_nxt = 1'b1;
          end
        end
        OP_SHOW: begin
          if (idle) begin
            pix_nxt       = '0;
            bit_nxt       = '0;
            slot_nxt      = '0;
            latch_cnt_nxt = '0;
            send_nxt      = S_SEND;
            ram_re        = 1'b1;
            ram_rd_addr   = '0;
            vld_q_nxt     = valid_r[0];
            ctl_nxt       = C_LOAD;
            out_acc_nxt   = 1'b1;
            // every bit starts high
            out_line_nxt  = 1'b1;
          end
        end
        default: begin
        end
      endcase
      out_busy_nxt = (send_nxt != S_IDLE);
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r         <= C_IDLE;
      send_r        <= S_IDLE;
      pix_r         <= '0;
      bit_r         <= '0;
      slot_r        <= '0;
      shift_r       <= '0;
      latch_cnt_r   <= '0;
      latch_ticks_r <= LATCH_RESET;
      fill_r        <= '0;
      valid_r       <= '0;
      vld_q_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      out_line_r    <= 1'b0;
      out_busy_r    <= 1'b0;
      out_acc_r     <= 1'b0;
    end else begin
      ctl_r         <= ctl_nxt;
      send_r        <= send_nxt;
      pix_r         <= pix_nxt;
      bit_r         <= bit_nxt;
      slot_r        <= slot_nxt;
      shift_r       <= shift_nxt;
      latch_cnt_r   <= latch_cnt_nxt;
      latch_ticks_r <= latch_ticks_nxt;
      fill_r        <= fill_nxt;
      valid_r       <= valid_nxt;
      vld_q_r       <= vld_q_nxt;
      out_valid_r   <= out_valid_nxt;
      out_line_r    <= out_line_nxt;
      out_busy_r    <= out_busy_nxt;
      out_acc_r     <= out_acc_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_line     = out_line_r;
  assign out_busy_res = out_busy_r;
  assign out_accepted = out_acc_r;

  // Checks
  `ALED_ASSERT_NEXT(a_result_follows_transfer, start && !busy, out_valid)
  `ALED_ASSERT_NOW(a_result_has_transfer, out_valid, $past(start && !busy))
  `ALED_ASSERT_NEXT(a_load_one_cycle, ctl_r == C_LOAD, ctl_r == C_IDLE)
  `ALED_ASSERT_NOW(a_tick_not_accepted, out_valid && out_accepted,
                   $past(in_op) != OP_TICK)
  `ALED_ASSERT_NOW(a_idle_counters_clear, send_r == S_IDLE,
                   slot_r == '0 && bit_r == '0 && pix_r == '0)

endmodule

`default_nettype wire
